// ===== sv/fdre_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractional divider register encoder package
// Shared types, control word layout and microcode program of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fdre_pkg;

    localparam int unsigned PC_W      = 5;
    localparam int unsigned QUO_W     = 27;  // 128*b needs 27 bits
    localparam int unsigned DEN_W     = 20;
    localparam int unsigned P1_W      = 18;
    localparam int unsigned CNT_W     = 5;
    localparam logic [CNT_W-1:0] DIV_LAST_COUNT = CNT_W'(QUO_W - 1);
    localparam logic [P1_W-1:0]  P1_OFFSET      = P1_W'(512);

    // Command kinds
    localparam logic [1:0] KIND_PLL  = 2'd0;
    localparam logic [1:0] KIND_MS   = 2'd1;
    localparam logic [1:0] KIND_RDIV = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Jump targets in the program
    localparam logic [PC_W-1:0] STEP_ACCEPT = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_DIV    = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_MS     = PC_W'(14);
    localparam logic [PC_W-1:0] STEP_RDIV   = PC_W'(22);
    localparam logic [PC_W-1:0] STEP_BAD    = PC_W'(23);

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_TEST,
        OP_DIV,
        OP_CALC,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_KIND1,
        COND_KIND2,
        COND_KIND3,
        COND_DEN0,
        COND_CNT_NZ
    } cond_t;

    typedef enum logic [3:0] {
        SEL_ZERO,
        SEL_P3_LO,
        SEL_P3_MID,
        SEL_P1_TOP,
        SEL_P1_MID,
        SEL_P1_LO,
        SEL_MIX,
        SEL_P2_MID,
        SEL_P2_LO,
        SEL_SHADOW_P1,
        SEL_SHADOW_R
    } sel_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic [7:0]      addr;
        sel_t            sel;
        logic            last;
        logic            bad;
        logic            shadow_wr;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic emit_ok;
        logic kind1;
        logic kind2;
        logic kind3;
        logic den0;
        logic cnt_nz;
    } status_t;

    function automatic ctrl_t mk_word(input op_t op, input cond_t cond,
                                      input logic [PC_W-1:0] target,
                                      input logic [7:0] addr, input sel_t sel,
                                      input logic last, input logic bad,
                                      input logic shadow_wr);
        ctrl_t w;
        w.op        = op;
        w.cond      = cond;
        w.target    = target;
        w.addr      = addr;
        w.sel       = sel;
        w.last      = last;
        w.bad       = bad;
        w.shadow_wr = shadow_wr;
        return w;
    endfunction

    // Microcode program
    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            5'd0:  w = mk_word(OP_ACCEPT, COND_NEXT, STEP_ACCEPT, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            5'd1:  w = mk_word(OP_TEST, COND_KIND3, STEP_ACCEPT, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            5'd2:  w = mk_word(OP_TEST, COND_KIND2, STEP_RDIV, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            5'd3:  w = mk_word(OP_TEST, COND_DEN0, STEP_BAD, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            5'd4:  w = mk_word(OP_DIV, COND_CNT_NZ, STEP_DIV, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            5'd5:  w = mk_word(OP_CALC, COND_KIND1, STEP_MS, 8'h00, SEL_ZERO, 1'b0, 1'b0, 1'b0);
            // PLL feedback writes
            5'd6:  w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1B, SEL_P3_LO, 1'b0, 1'b0, 1'b0);
            5'd7:  w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1A, SEL_P3_MID, 1'b0, 1'b0, 1'b0);
            5'd8:  w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1C, SEL_P1_TOP, 1'b0, 1'b0, 1'b0);
            5'd9:  w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1D, SEL_P1_MID, 1'b0, 1'b0, 1'b0);
            5'd10: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1E, SEL_P1_LO, 1'b0, 1'b0, 1'b0);
            5'd11: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h1F, SEL_MIX, 1'b0, 1'b0, 1'b0);
            5'd12: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h20, SEL_P2_MID, 1'b0, 1'b0, 1'b0);
            5'd13: w = mk_word(OP_EMIT, COND_ALWAYS, STEP_ACCEPT, 8'h21, SEL_P2_LO, 1'b1, 1'b0, 1'b0);
            // Multisynth writes
            5'd14: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h2B, SEL_P3_LO, 1'b0, 1'b0, 1'b0);
            5'd15: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h2A, SEL_P3_MID, 1'b0, 1'b0, 1'b0);
            5'd16: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h31, SEL_P2_LO, 1'b0, 1'b0, 1'b0);
            5'd17: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h30, SEL_P2_MID, 1'b0, 1'b0, 1'b0);
            5'd18: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h2F, SEL_MIX, 1'b0, 1'b0, 1'b0);
            5'd19: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h2E, SEL_P1_LO, 1'b0, 1'b0, 1'b0);
            5'd20: w = mk_word(OP_EMIT, COND_NEXT, STEP_ACCEPT, 8'h2D, SEL_P1_MID, 1'b0, 1'b0, 1'b0);
            5'd21: w = mk_word(OP_EMIT, COND_ALWAYS, STEP_ACCEPT, 8'h2C, SEL_SHADOW_P1,
                               1'b1, 1'b0, 1'b1);
            // R divider write and zero-denominator flag
            5'd22: w = mk_word(OP_EMIT, COND_ALWAYS, STEP_ACCEPT, 8'h2C, SEL_SHADOW_R,
                               1'b1, 1'b0, 1'b1);
            5'd23: w = mk_word(OP_EMIT, COND_ALWAYS, STEP_ACCEPT, 8'h00, SEL_ZERO, 1'b1, 1'b1, 1'b0);
            default: w = mk_word(OP_TEST, COND_ALWAYS, STEP_ACCEPT, 8'h00, SEL_ZERO,
                                 1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    // R divider value to 3-bit code; anything but a power of two gives 7
    function automatic logic [2:0] rdiv_code(input logic [7:0] d);
        logic [2:0] code;
        code = 3'd7;
        for (int i = 0; i < 8; i++) begin
            if (d == (8'd1 << i)) begin
                code = 3'(i);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fdre_if.sv =====
// ----------------------------------------------------------------------------
// Encoder channel interfaces
// Command channel and register write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdre_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] ratio_whole;
    logic [19:0] ratio_num;
    logic [19:0] ratio_den;
    logic [7:0]  out_div;

    modport source (output valid, kind, ratio_whole, ratio_num, ratio_den, out_div,
                    input ready);
    modport sink   (input valid, kind, ratio_whole, ratio_num, ratio_den, out_div,
                    output ready);
endinterface

interface fdre_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last;
    logic       bad_ratio;

    modport source (output valid, reg_address, reg_data, last, bad_ratio, input ready);
    modport sink   (input valid, reg_address, reg_data, last, bad_ratio, output ready);
endinterface

`default_nettype wire

// ===== sv/fractional_divider_register_encoder.sv =====
// ----------------------------------------------------------------------------
// Fractional divider register encoder
// Turns ratio and R-divider commands into device register write transactions.
// ----------------------------------------------------------------------------
// Ratio command: steps are 1 accept, 3 dispatch, 27 divide steps of one bit, 1 P1
//   add and 8 writes; the bit-serial divider takes most of them. One command is in
//   flight at a time.
// R-divider command: one write; zero denominator: one flagged write; unused kind: none.
// First write leaves the output register in the cycle after its step.
// Reset (rst_n low, asynchronous) returns to the accept step, empties the output
//   register and clears the divider register shadow.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_divider_register_encoder
    import fdre_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fdre_cmd_if.sink  cmd,
    fdre_wr_if.source wr
);

    ctrl_t   ctrl;
    status_t status;

    // Latched command fields
    logic [1:0]       kind_reg;
    logic [11:0]      whole_reg;
    logic [DEN_W-1:0] den_reg;
    logic [7:0]       odiv_reg;

    // Divider: remainder and quotient/dividend shift register
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P1_W-1:0]  p1_reg;

    logic [7:0] shadow_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_addr_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_bad_reg;

    logic             cmd_fire;
    logic             emit_ok;
    logic             emit_fire;
    logic [DEN_W:0]   partial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [7:0]       emit_data;

    fdre_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Take a command only on the accept step
    assign cmd.ready = (ctrl.op == OP_ACCEPT);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Output slot free when empty or being drained this cycle
    assign emit_ok   = !out_valid_reg || wr.ready;
    assign emit_fire = (ctrl.op == OP_EMIT) && emit_ok;

    assign status.accept  = cmd_fire;
    assign status.emit_ok = emit_ok;
    assign status.kind1   = (kind_reg == KIND_MS);
    assign status.kind2   = (kind_reg == KIND_RDIV);
    assign status.kind3   = (kind_reg == KIND_NONE);
    assign status.den0    = (den_reg == '0);
    assign status.cnt_nz  = (cnt_reg != '0);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign partial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = partial - {1'b0, den_reg};
    assign fits    = (partial >= {1'b0, den_reg});

    // Byte selection for the current write; P2 is the remainder, P3 the denominator
    always_comb
    begin
        case (ctrl.sel)
            SEL_P3_LO:     emit_data = den_reg[7:0];
            SEL_P3_MID:    emit_data = den_reg[15:8];
            SEL_P1_TOP:    emit_data = {6'b0, p1_reg[17:16]};
            SEL_P1_MID:    emit_data = p1_reg[15:8];
            SEL_P1_LO:     emit_data = p1_reg[7:0];
            SEL_MIX:       emit_data = {den_reg[19:16], rem_reg[19:16]};
            SEL_P2_MID:    emit_data = rem_reg[15:8];
            SEL_P2_LO:     emit_data = rem_reg[7:0];
            SEL_SHADOW_P1: emit_data = {shadow_reg[7:2], p1_reg[17:16]};
            SEL_SHADOW_R:  emit_data = {shadow_reg[7], rdiv_code(odiv_reg), shadow_reg[3:0]};
            default:       emit_data = 8'h00;
        endcase
    end

    // Datapath registers, driven by the current control word
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            kind_reg  <= cmd.kind;
            whole_reg <= cmd.ratio_whole;
            den_reg   <= cmd.ratio_den;
            odiv_reg  <= cmd.out_div;
            rem_reg   <= '0;
            quo_reg   <= {cmd.ratio_num, 7'b0};
            cnt_reg   <= DIV_LAST_COUNT;
        end
        else if (ctrl.op == OP_DIV)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (ctrl.op == OP_CALC)
        begin
            // P1 = 128a + q - 512, wrapped to 18 bits
            p1_reg <= {whole_reg[10:0], 7'b0} + quo_reg[P1_W-1:0] - P1_OFFSET;
        end

        if (emit_fire)
        begin
            out_addr_reg <= ctrl.addr;
            out_data_reg <= emit_data;
            out_last_reg <= ctrl.last;
            out_bad_reg  <= ctrl.bad;
        end
    end

    // Control state: shadow of the shared divider register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_fire && ctrl.shadow_wr)
            begin
                shadow_reg <= emit_data;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign wr.valid       = out_valid_reg;
    assign wr.reg_address = out_addr_reg;
    assign wr.reg_data    = out_data_reg;
    assign wr.last        = out_last_reg;
    assign wr.bad_ratio   = out_bad_reg;

endmodule

`default_nettype wire

// ===== sv/fdre_seq.sv =====
// ----------------------------------------------------------------------------
// Encoder sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module fdre_seq
    import fdre_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            step_done;
    logic            taken;

    assign ctrl = rom_word(pc_reg);

    // Hold on accept and emit steps until the handshake side allows it
    always_comb
    begin
        case (ctrl.op)
            OP_ACCEPT: step_done = status.accept;
            OP_EMIT:   step_done = status.emit_ok;
            default:   step_done = 1'b1;
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS: taken = 1'b1;
            COND_KIND1:  taken = status.kind1;
            COND_KIND2:  taken = status.kind2;
            COND_KIND3:  taken = status.kind3;
            COND_DEN0:   taken = status.den0;
            COND_CNT_NZ: taken = status.cnt_nz;
            default:     taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (step_done)
        begin
            pc_next = taken ? ctrl.target : pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_ACCEPT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/fractional_divider_register_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// Fractional divider register encoder testbench
// Drives ratio, R-divider and unused commands through the command channel,
// predicts every register write transaction (including the divider register
// shadow) and checks each write on the output channel in order. Both sides of
// the handshake idle at random, with stretches of full-rate traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_divider_register_encoder_tb
    import fdre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD      = 4;
    localparam int unsigned RANDOM_COMMANDS = 280;
    localparam int unsigned DRAIN_CYCLES    = 64;
    // Slowest run: ~310 commands with every write stalled and every gap at its longest;
    // allow ten times that.
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // Register addresses of the device
    localparam logic [7:0] PLL_P3_LO_ADDR  = 8'h1B;
    localparam logic [7:0] PLL_P3_MID_ADDR = 8'h1A;
    localparam logic [7:0] PLL_P1_TOP_ADDR = 8'h1C;
    localparam logic [7:0] PLL_P1_MID_ADDR = 8'h1D;
    localparam logic [7:0] PLL_P1_LO_ADDR  = 8'h1E;
    localparam logic [7:0] PLL_MIX_ADDR    = 8'h1F;
    localparam logic [7:0] PLL_P2_MID_ADDR = 8'h20;
    localparam logic [7:0] PLL_P2_LO_ADDR  = 8'h21;
    localparam logic [7:0] MS_P3_LO_ADDR   = 8'h2B;
    localparam logic [7:0] MS_P3_MID_ADDR  = 8'h2A;
    localparam logic [7:0] MS_P2_LO_ADDR   = 8'h31;
    localparam logic [7:0] MS_P2_MID_ADDR  = 8'h30;
    localparam logic [7:0] MS_MIX_ADDR     = 8'h2F;
    localparam logic [7:0] MS_P1_LO_ADDR   = 8'h2E;
    localparam logic [7:0] MS_P1_MID_ADDR  = 8'h2D;
    localparam logic [7:0] DIV_REG_ADDR    = 8'h2C;
    localparam logic [7:0] NO_WRITE_ADDR   = 8'h00;

    localparam logic [2:0] RDIV_CODE_OTHER = 3'd7;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] data;
        logic       last;
        logic       bad_ratio;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    fdre_cmd_if cmd_ch();
    fdre_wr_if  wr_ch();

    fractional_divider_register_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .wr    (wr_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicted write transactions, oldest first, and our copy of the
    // shared divider register as the device should now hold it.
    reg_write_t  pending_writes[$];
    logic [7:0]  div_reg_shadow = 8'h00;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    // Clear to run both sides at full rate.
    bit          pacing_on      = 1'b1;
    int unsigned sink_stall     = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Map an R divider value to its 3-bit code: powers of two 1..128 give
    // their exponent, anything else the catch-all code.
    function automatic logic [2:0] rdiv_field(input logic [7:0] value);
        if ($countones(value) == 1) begin
            return 3'($clog2(value));
        end
        return RDIV_CODE_OTHER;
    endfunction

    function automatic void queue_write(input logic [7:0] address, input logic [7:0] data,
                                        input logic last, input logic bad_ratio);
        reg_write_t w;
        w.address   = address;
        w.data      = data;
        w.last      = last;
        w.bad_ratio = bad_ratio;
        pending_writes.push_back(w);
    endfunction

    // Work out every write an accepted command must produce, in device order,
    // and advance the divider register shadow where the command touches it.
    function automatic void encode_command(input logic [1:0] kind, input logic [11:0] whole,
                                           input logic [19:0] num, input logic [19:0] den,
                                           input logic [7:0] out_div);
        logic [63:0] scaled;
        logic [63:0] quot;
        logic [17:0] p1;
        logic [19:0] p2;
        logic [19:0] p3;
        logic [7:0]  mix;
        logic [7:0]  next_shadow;

        if (kind == KIND_NONE) begin
            return;
        end
        if (kind == KIND_RDIV) begin
            next_shadow    = {div_reg_shadow[7], rdiv_field(out_div), div_reg_shadow[3:0]};
            div_reg_shadow = next_shadow;
            queue_write(DIV_REG_ADDR, next_shadow, 1'b1, 1'b0);
            return;
        end
        // A zero denominator is flagged once and writes nothing.
        if (den == 20'd0) begin
            queue_write(NO_WRITE_ADDR, 8'h00, 1'b1, 1'b1);
            return;
        end

        // Exact floor division; everything wraps to its register width.
        scaled = 64'(num) << 7;
        quot   = scaled / 64'(den);
        p1     = 18'(64'(whole) * 64'd128 + quot - 64'd512);
        p2     = 20'(scaled - 64'(den) * quot);
        p3     = den;
        mix    = {p3[19:16], p2[19:16]};

        if (kind == KIND_PLL) begin
            queue_write(PLL_P3_LO_ADDR,  p3[7:0],          1'b0, 1'b0);
            queue_write(PLL_P3_MID_ADDR, p3[15:8],         1'b0, 1'b0);
            queue_write(PLL_P1_TOP_ADDR, {6'd0, p1[17:16]}, 1'b0, 1'b0);
            queue_write(PLL_P1_MID_ADDR, p1[15:8],         1'b0, 1'b0);
            queue_write(PLL_P1_LO_ADDR,  p1[7:0],          1'b0, 1'b0);
            queue_write(PLL_MIX_ADDR,    mix,              1'b0, 1'b0);
            queue_write(PLL_P2_MID_ADDR, p2[15:8],         1'b0, 1'b0);
            queue_write(PLL_P2_LO_ADDR,  p2[7:0],          1'b1, 1'b0);
        end else begin
            next_shadow = {div_reg_shadow[7:2], p1[17:16]};
            queue_write(MS_P3_LO_ADDR,  p3[7:0],     1'b0, 1'b0);
            queue_write(MS_P3_MID_ADDR, p3[15:8],    1'b0, 1'b0);
            queue_write(MS_P2_LO_ADDR,  p2[7:0],     1'b0, 1'b0);
            queue_write(MS_P2_MID_ADDR, p2[15:8],    1'b0, 1'b0);
            queue_write(MS_MIX_ADDR,    mix,         1'b0, 1'b0);
            queue_write(MS_P1_LO_ADDR,  p1[7:0],     1'b0, 1'b0);
            queue_write(MS_P1_MID_ADDR, p1[15:8],    1'b0, 1'b0);
            queue_write(DIV_REG_ADDR,   next_shadow, 1'b1, 1'b0);
            div_reg_shadow = next_shadow;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------

    // Present one command after a random gap, hold it until the transaction
    // completes, then predict its writes. Valid stays high across back-to-back
    // commands so it never gets two updates in one time step.
    task automatic send_command(input logic [1:0] kind, input logic [11:0] whole,
                                input logic [19:0] num, input logic [19:0] den,
                                input logic [7:0] out_div);
        int unsigned gap;

        gap = pacing_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= kind;
        cmd_ch.ratio_whole <= whole;
        cmd_ch.ratio_num   <= num;
        cmd_ch.ratio_den   <= den;
        cmd_ch.out_div     <= out_div;
        @(posedge clk);
        while (!cmd_ch.ready) begin
            @(posedge clk);
        end
        encode_command(kind, whole, num, den, out_div);
    endtask

    // ------------------------------------------------------------------------
    // Write channel: random back-pressure and checking
    // ------------------------------------------------------------------------

    // After each write transaction, drop ready for a random number of cycles.
    always @(posedge clk) begin
        if (wr_ch.valid && wr_ch.ready) begin
            sink_stall = pacing_on ? $urandom_range(0, 8) : 0;
            if (sink_stall != 0) begin
                wr_ch.ready <= 1'b0;
            end
        end else if (rst_n && !wr_ch.ready) begin
            if (sink_stall != 0) begin
                sink_stall--;
            end
            if (sink_stall == 0) begin
                wr_ch.ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: write mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Compare each completed write with the oldest prediction, field by field.
    always @(posedge clk) begin
        reg_write_t want;
        if (rst_n && wr_ch.valid && wr_ch.ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("unpredicted write address", wr_ch.reg_address, NO_WRITE_ADDR);
            end else begin
                want = pending_writes.pop_front();
                if (wr_ch.reg_address !== want.address) begin
                    report_mismatch("reg_address", wr_ch.reg_address, want.address);
                end
                if (wr_ch.reg_data !== want.data) begin
                    report_mismatch("reg_data", wr_ch.reg_data, want.data);
                end
                if (wr_ch.last !== want.last) begin
                    report_mismatch("last", 8'(wr_ch.last), 8'(want.last));
                end
                if (wr_ch.bad_ratio !== want.bad_ratio) begin
                    report_mismatch("bad_ratio", 8'(wr_ch.bad_ratio), 8'(want.bad_ratio));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // PLL feedback ratios at the corners of a, b and c, including the
    // negative wrap of P1 and a numerator well above the denominator.
    task automatic test_pll_ratios();
        send_command(KIND_PLL, 12'd0,    20'd0,      20'd1,       8'h00);
        send_command(KIND_PLL, 12'hFFF,  20'hFFFFF,  20'hFFFFF,   8'hFF);
        send_command(KIND_PLL, 12'd36,   20'd0,      20'hFFFFF,   8'h00);
        send_command(KIND_PLL, 12'hFFF,  20'hFFFFF,  20'd1,       8'h00);
        send_command(KIND_PLL, 12'd35,   20'd123456, 20'd1000000, 8'h55);
    endtask

    // Every R divider power of two, then zero and an all-ones value which
    // both fall back to the catch-all code.
    task automatic test_rdiv_codes();
        for (int i = 0; i < 8; i++) begin
            send_command(KIND_RDIV, 12'd0, 20'd0, 20'd0, 8'(1 << i));
        end
        send_command(KIND_RDIV, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 8'h00);
        send_command(KIND_RDIV, 12'd0,   20'd0,     20'd0,     8'hFF);
    endtask

    // Multisynth ratios; the last write merges P1's top bits into the shadow
    // left behind by the R divider commands.
    task automatic test_multisynth_ratios();
        send_command(KIND_MS, 12'd4,    20'd0,      20'd1,       8'h00);
        send_command(KIND_MS, 12'hFFF,  20'hFFFFF,  20'd1,       8'hAA);
        send_command(KIND_MS, 12'd0,    20'd1,      20'hFFFFF,   8'h00);
        send_command(KIND_MS, 12'd900,  20'd77777,  20'd99999,   8'h00);
    endtask

    // A zero denominator gives a single flagged transaction for either kind.
    task automatic test_zero_denominator();
        send_command(KIND_PLL, 12'd50,  20'd1234,  20'd0, 8'h00);
        send_command(KIND_MS,  12'hFFF, 20'hFFFFF, 20'd0, 8'hFF);
    endtask

    // The unused kind must produce nothing, whatever the other fields hold.
    task automatic test_unused_kind();
        send_command(KIND_NONE, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 8'hFF);
        send_command(KIND_NONE, 12'd0,   20'd0,     20'd0,     8'h00);
    endtask

    // Mostly well-formed ratios with random content, plus R divider commands,
    // zero denominators and ignored commands. Pacing switches off now and then.
    task automatic test_random_traffic();
        int unsigned counted;
        int unsigned pick;
        logic [1:0]  kind;
        logic [11:0] whole;
        logic [19:0] num;
        logic [19:0] den;
        logic [7:0]  out_div;

        counted = 0;
        while (counted < RANDOM_COMMANDS) begin
            if (counted % 40 == 0) begin
                pacing_on = ($urandom_range(0, 3) != 0);
            end
            pick    = $urandom_range(0, 99);
            whole   = 12'($urandom);
            num     = 20'($urandom);
            den     = 20'($urandom);
            out_div = 8'($urandom);
            // Small denominators stress the large quotients.
            if ($urandom_range(0, 3) == 0) begin
                den = 20'($urandom_range(1, 15));
            end
            if (den == 20'd0) begin
                den = 20'd1;
            end
            // Keep b below c most of the time, as a real fraction would be.
            if ($urandom_range(0, 4) != 0) begin
                num = num % den;
            end
            if (pick < 40) begin
                kind = KIND_PLL;
            end else if (pick < 80) begin
                kind = KIND_MS;
            end else if (pick < 92) begin
                kind = KIND_RDIV;
                // Favour valid powers of two over the catch-all.
                if ($urandom_range(0, 1) == 0) begin
                    out_div = 8'(1 << $urandom_range(0, 7));
                end
            end else if (pick < 96) begin
                kind = KIND_NONE;
            end else begin
                kind = ($urandom_range(0, 1) == 0) ? KIND_PLL : KIND_MS;
                den  = 20'd0;
            end
            send_command(kind, whole, num, den, out_div);
            if (kind != KIND_NONE) begin
                counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = KIND_PLL;
        cmd_ch.ratio_whole = 12'd0;
        cmd_ch.ratio_num   = 20'd0;
        cmd_ch.ratio_den   = 20'd0;
        cmd_ch.out_div     = 8'd0;
        wr_ch.ready        = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pll_ratios();
        test_rdiv_codes();
        test_multisynth_ratios();
        test_zero_denominator();
        test_unused_kind();
        test_random_traffic();
        cmd_ch.valid <= 1'b0;

        // Drain outstanding writes, then hold a while to catch stray ones.
        while (pending_writes.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("PASS fractional_divider_register_encoder");
        end else begin
            $display("FAIL fractional_divider_register_encoder");
        end
        $finish;
    end

    // Watchdog: end the run if the traffic stalls for good.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timed out with %0d writes pending", $time, pending_writes.size());
        $display("FAIL fractional_divider_register_encoder");
        $finish;
    end

endmodule

`default_nettype wire
